@@ hdl/hcbd_pkg.sv @@
`default_nettype none

package hcbd_pkg;

  localparam int SIZE_DIGITS_DEF = 8;
  localparam int CFG_IDX_W       = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKED_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_LENGTH  = 1'd1;

  typedef enum logic [2:0] {
    PH_SIZE = 3'd0,
    PH_DATA = 3'd1,
    PH_SKIP = 3'd2,
    PH_DONE = 3'd3,
    PH_ERR  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_req_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [31:0] payload_count;
  } out_req_t;

endpackage

`default_nettype wire

@@ hdl/http_chunked_body_decoder.sv @@
// HTTP body decoder, chunked transfer coding or fixed content length.
// Input channel: in_valid / in_stall / in_req carry one body byte per request
//   (in_byte, restart). A request is taken on a clock edge with in_valid high
//   and in_stall low. restart=1 starts a new body with this byte.
// Output channel: out_valid / out_stall / out_req carry exactly one result per
//   input request: out_valid flag with out_byte (payload or zero), status
//   (0 size line, 1 data, 2 delimiter skip, 3 done, 4 error) and the running
//   payload_count.
// Config channel: cfg_valid / cfg_ready / cfg_index / cfg_data. Index 0 is
//   chunked_mode, index 1 is the body length. cfg_ready is always high; write
//   only while no request is in flight.
// Results are registered in the output buffer when their requests are taken.
// Throughput: one byte per cycle when not stalled; next-state logic is one
//   short stage between the decoder state registers and the output register.
// Stall: results sit in a two-entry buffer (output register plus skid slot),
//   so a request can be taken while a result waits. in_stall goes high only
//   once both entries are occupied.
// Reset (rst, synchronous): clears decoder state, both config registers and
//   empties the output buffer.
`default_nettype none

module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int SIZE_DIGITS = SIZE_DIGITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_req_t              in_req,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_req_t                  out_req,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic        chunked_mode;
  logic [31:0] body_length;
  logic        in_fire;
  out_req_t    res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode <= 1'b0;
      body_length  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHUNKED_MODE: chunked_mode <= cfg_data[0];
        REG_BODY_LENGTH:  body_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  hcbd_engine #(
    .SIZE_DIGITS(SIZE_DIGITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .chunked_mode (chunked_mode),
    .body_length  (body_length),
    .in_fire      (in_fire),
    .in_req       (in_req),
    .res          (res)
  );

  hcbd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_req  (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

`ifndef SYNTHESIS
  // skid slot only fills behind an occupied output register
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // a request taken into an empty buffer shows up next cycle
  a_fill_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid) |=> out_valid)
    else $error("result missing after request");

  // payload byte never reported with an error or size-line status
  a_no_byte_on_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_req.out_valid) |-> (out_req.status != PH_ERR &&
                                          out_req.status != PH_SIZE))
    else $error("payload byte with bad status");

  // out_byte is zero whenever no payload byte is flagged
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_req.out_valid) |-> (out_req.out_byte == 8'd0))
    else $error("nonzero out_byte without payload flag");
`endif

endmodule

`default_nettype wire

@@ hdl/hcbd_engine.sv @@
`default_nettype none

// Decoder state and per-byte next-state logic. State advances on each accepted byte.
module hcbd_engine import hcbd_pkg::*; #(
  parameter int SIZE_DIGITS = SIZE_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        chunked_mode,
  input  wire logic [31:0] body_length,
  input  wire logic        in_fire,
  input  wire in_req_t     in_req,
  output out_req_t         res
);

  localparam int DC_W = $clog2(SIZE_DIGITS + 1);
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;

  phase_t          phase;
  logic [31:0]     bytes_left;
  logic [DC_W-1:0] digit_count;
  logic            size_ended;
  logic [1:0]      skip_left;
  logic [31:0]     forwarded_total;

  phase_t          phase_next;
  logic [31:0]     bytes_left_next;
  logic [DC_W-1:0] digit_count_next;
  logic            size_ended_next;
  logic [1:0]      skip_left_next;
  logic [31:0]     forwarded_total_next;

  phase_t          cur_phase;
  logic [31:0]     cur_left;
  logic [DC_W-1:0] cur_dc;
  logic            cur_se;
  logic [1:0]      cur_skip;
  logic [31:0]     cur_total;
  logic [31:0]     total_inc;
  logic            hex_ok;
  logic [3:0]      hex_val;
  logic            fwd;
  logic [7:0]      c;

  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, ch[3:0]};
    else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
      r = {1'b1, ch[3:0] + 4'd9};
    return r;
  endfunction

  always_comb begin
    c = in_req.in_byte;
    {hex_ok, hex_val} = hex_decode(c);

    // restart clears decoder state ahead of this byte
    if (in_req.restart) begin
      cur_phase = PH_SIZE;
      cur_left  = '0;
      cur_dc    = '0;
      cur_se    = 1'b0;
      cur_skip  = '0;
      cur_total = '0;
    end else begin
      cur_phase = phase;
      cur_left  = bytes_left;
      cur_dc    = digit_count;
      cur_se    = size_ended;
      cur_skip  = skip_left;
      cur_total = forwarded_total;
    end

    total_inc = (cur_total != '1) ? cur_total + 32'd1 : cur_total;

    phase_next           = cur_phase;
    bytes_left_next      = cur_left;
    digit_count_next     = cur_dc;
    size_ended_next      = cur_se;
    skip_left_next       = cur_skip;
    forwarded_total_next = cur_total;
    fwd                  = 1'b0;

    if (cur_phase == PH_DONE || cur_phase == PH_ERR) begin
      // past the end: ignore
    end else if (!chunked_mode) begin
      if (cur_total < body_length) begin
        fwd                  = 1'b1;
        forwarded_total_next = total_inc;
        // no saturation possible here, so done means one short before
        phase_next = (cur_total + 32'd1 == body_length) ? PH_DONE : PH_DATA;
      end else begin
        phase_next = PH_DONE;
      end
    end else if (cur_phase == PH_SIZE) begin
      if (c == CH_LF) begin
        phase_next       = (cur_dc == '0 || cur_left == '0) ? PH_DONE : PH_DATA;
        digit_count_next = '0;
        size_ended_next  = 1'b0;
      end else if (!cur_se) begin
        if (c == CH_SP && cur_dc == '0) begin
          // leading space
        end else if (!hex_ok) begin
          size_ended_next = 1'b1;
        end else if (cur_dc >= DC_W'(SIZE_DIGITS)) begin
          phase_next = PH_ERR;
        end else begin
          bytes_left_next  = (|cur_left[31:28]) ? '1 : {cur_left[27:0], hex_val};
          digit_count_next = cur_dc + DC_W'(1);
        end
      end
    end else if (cur_phase == PH_DATA) begin
      if (cur_left == '0) begin
        phase_next     = PH_SKIP;
        skip_left_next = 2'd1;
      end else begin
        fwd                  = 1'b1;
        forwarded_total_next = total_inc;
        bytes_left_next      = cur_left - 32'd1;
        if (cur_left == 32'd1) begin
          phase_next     = PH_SKIP;
          skip_left_next = 2'd2;
        end
      end
    end else begin
      skip_left_next = (cur_skip != '0) ? cur_skip - 2'd1 : cur_skip;
      if (skip_left_next == '0) begin
        phase_next       = PH_SIZE;
        bytes_left_next  = '0;
        digit_count_next = '0;
        size_ended_next  = 1'b0;
      end
    end

    res.out_valid     = fwd;
    res.out_byte      = fwd ? c : 8'd0;
    res.status        = phase_next;
    res.payload_count = forwarded_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      bytes_left      <= '0;
      digit_count     <= '0;
      size_ended      <= 1'b0;
      skip_left       <= '0;
      forwarded_total <= '0;
    end else if (in_fire) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      digit_count     <= digit_count_next;
      size_ended      <= size_ended_next;
      skip_left       <= skip_left_next;
      forwarded_total <= forwarded_total_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/hcbd_outbuf.sv @@
`default_nettype none

// Two-entry result buffer: main output register plus skid slot.
module hcbd_outbuf import hcbd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire out_req_t push_req,
  output logic          full,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_req_t      out_req
);

  logic     main_v;
  out_req_t main_q;
  logic     skid_v;
  out_req_t skid_q;
  logic     pop;

  assign pop       = main_v && !out_stall;
  assign full      = skid_v;
  assign out_valid = main_v;
  assign out_req   = main_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (pop) begin
      if (skid_v) begin
        main_q <= skid_q;
        skid_v <= 1'b0;
      end else if (push) begin
        main_q <= push_req;
      end else begin
        main_v <= 1'b0;
      end
    end else if (push) begin
      if (!main_v) begin
        main_q <= push_req;
        main_v <= 1'b1;
      end else begin
        skid_q <= push_req;
        skid_v <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
